// File: design/complex_component_extract_macros.svh
`ifndef COMPLEX_COMPONENT_EXTRACT_MACROS_SVH
`define COMPLEX_COMPONENT_EXTRACT_MACROS_SVH

// same-cycle implication, off while reset is high
`define CCE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define CCE_ASSERT_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cce_pkg.sv
`default_nettype none

package cce_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_DIM_DEF       = 1024;
   localparam int GUARD_BITS        = 14;
   localparam int GAIN_W            = 30;
   localparam int QUEUE_DEPTH       = 4;
   localparam int STATUS_W          = 2;
   localparam int MODE_W            = 3;
   localparam int PHASE_W           = 16;
   localparam int ANGLE_W           = 34;
   localparam int CSR_INDEX_W       = 1;

   localparam logic [GAIN_W-1:0] GAIN_FIX = 30'd652032874;

   localparam logic [MODE_W-1:0] MODE_REAL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_IMAG   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAG    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PHASE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MAG_SQ = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MODE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // atan(2^-i) in units of pi/2^31
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_REAL,
      KIND_IMAG,
      KIND_MAG,
      KIND_PHASE,
      KIND_MAG_SQ
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [STATUS_W-1:0]   status;
   } ctl_type;

endpackage

`default_nettype wire

// File: design/cce_front.sv
`default_nettype none

module cce_front
   import cce_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int MAX_DIM      = MAX_DIM_DEF,
   parameter int POS_W        = $clog2(MAX_DIM),
   parameter int CFG_W        = POS_W + 1
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  signed [SAMPLE_WIDTH-1:0] req_real,
   input  wire  signed [SAMPLE_WIDTH-1:0] req_imag,
   input  wire         [POS_W-1:0]        req_pos_x,
   input  wire         [POS_W-1:0]        req_pos_y,
   input  wire         [MODE_W-1:0]       req_mode,
   input  wire                            csr_wr_en,
   input  wire         [CSR_INDEX_W-1:0]  csr_index,
   input  wire         [CFG_W-1:0]        csr_wr_data,
   output logic                           out_valid,
   input  wire                            out_ready,
   output ctl_type                        out_ctl,
   output logic signed [SAMPLE_WIDTH-1:0] out_real,
   output logic signed [SAMPLE_WIDTH-1:0] out_imag
);

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic             valid_ff, valid_in;
   ctl_type          ctl_ff, ctl_in;
   logic signed [SAMPLE_WIDTH-1:0] real_ff, imag_ff;
   logic             accept;
   logic             pos_ok;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en && (csr_index == CSR_FRAME_WIDTH)) begin
         frame_width_in = csr_wr_data;
      end
      if (csr_wr_en && (csr_index == CSR_FRAME_HEIGHT)) begin
         frame_height_in = csr_wr_data;
      end
   end

   assign pos_ok = ({1'b0, req_pos_x} < frame_width_ff) &&
                   ({1'b0, req_pos_y} < frame_height_ff);

   always_comb begin
      ctl_in.kind   = KIND_NONE;
      ctl_in.status = STATUS_OK;
      if (!pos_ok) begin
         ctl_in.status = STATUS_BAD_POS;
      end else begin
         case (req_mode)
            MODE_REAL:   ctl_in.kind = KIND_REAL;
            MODE_IMAG:   ctl_in.kind = KIND_IMAG;
            MODE_MAG:    ctl_in.kind = KIND_MAG;
            MODE_PHASE:  ctl_in.kind = KIND_PHASE;
            MODE_MAG_SQ: ctl_in.kind = KIND_MAG_SQ;
            default:     ctl_in.status = STATUS_BAD_MODE;
         endcase
      end
   end

   assign req_tready = !valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_W'(MAX_DIM);
         frame_height_ff <= CFG_W'(MAX_DIM);
         valid_ff        <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff  <= ctl_in;
         real_ff <= req_real;
         imag_ff <= req_imag;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_real  = real_ff;
   assign out_imag  = imag_ff;

endmodule

`default_nettype wire

// File: design/cce_queue.sv
`default_nettype none

module cce_queue
   import cce_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push_valid,
   output logic             push_ready,
   input  wire  [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  wire              pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/cce_back.sv
`default_nettype none

module cce_back
   import cce_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int VALUE_W       = 2 * SAMPLE_WIDTH + 1
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  ctl_type                        in_ctl,
   input  wire  signed [SAMPLE_WIDTH-1:0] in_real,
   input  wire  signed [SAMPLE_WIDTH-1:0] in_imag,
   output logic                           out_valid,
   input  wire                            out_ready,
   output logic        [VALUE_W-1:0]      out_value,
   output logic        [STATUS_W-1:0]     out_status
);

   localparam int SW        = SAMPLE_WIDTH;
   localparam int NS        = CORDIC_STAGES;
   localparam int XW        = SW + GUARD_BITS + 3;
   localparam int ZW        = ANGLE_W;
   localparam int LOW_W     = 16;
   localparam int HW        = XW - 1 - LOW_W;
   localparam int HC_W      = HW + GAIN_W;
   localparam int LC_W      = LOW_W + GAIN_W;
   localparam int PW        = HC_W + 1;
   localparam int MAG_SHIFT = GUARD_BITS + 14;
   localparam int SQ_W      = 2 * SW;

   localparam logic signed [ZW-1:0] Z_PI     = ZW'(64'd2147483648);
   localparam logic signed [ZW-1:0] Z_HALF   = ZW'(64'd32768);
   localparam logic signed [ZW-1:0] PH_MAX   = ZW'(2 ** (PHASE_W - 1) - 1);
   localparam logic signed [ZW-1:0] PH_MIN   = -ZW'(2 ** (PHASE_W - 1));
   localparam logic        [PW-1:0] MAG_HALF = PW'(1) << (MAG_SHIFT - 1);

   logic        en;
   logic [NS+1:0] valid_ff;

   logic signed [XW-1:0] x_ff [NS+1];
   logic signed [XW-1:0] x_in [NS+1];
   logic signed [XW-1:0] y_ff [NS+1];
   logic signed [XW-1:0] y_in [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic signed [ZW-1:0] z_in [NS+1];
   ctl_type              ctl_ff [NS+2];
   logic signed [SW-1:0] real_ff [NS+2];
   logic signed [SW-1:0] imag_ff [NS+2];
   logic                 zero_ff [NS+2];

   logic signed [XW-1:0] re_w, im_w;
   logic                 re_neg;

   logic [XW-2:0]        ux;
   logic [HC_W-1:0]      hc_in, hc_ff;
   logic [LC_W-1:0]      lc_full;
   logic [GAIN_W-1:0]    lc_in, lc_ff;
   logic signed [ZW-1:0] zr, zs;
   logic signed [PHASE_W-1:0] ph_in, ph_ff;
   logic signed [SQ_W-1:0] sq_re_w, sq_im_w;
   logic [SQ_W-1:0]      sq_re_ff, sq_im_ff;

   logic [PW-1:0]        p;
   logic [PW-1:0]        mag_w;
   logic [VALUE_W-1:0]   value_in, value_ff;
   logic                 out_valid_ff;
   logic [STATUS_W-1:0]  status_ff;

   assign en       = !out_valid_ff || out_ready;
   assign in_ready = en;

   // prerotation into the right half plane, then the micro-rotations
   always_comb begin
      re_w   = {{(XW - SW){in_real[SW-1]}}, in_real} <<< GUARD_BITS;
      im_w   = {{(XW - SW){in_imag[SW-1]}}, in_imag} <<< GUARD_BITS;
      re_neg = in_real[SW-1];
      x_in[0] = re_neg ? -re_w : re_w;
      y_in[0] = re_neg ? -im_w : im_w;
      if (!re_neg) begin
         z_in[0] = '0;
      end else if (!in_imag[SW-1]) begin
         z_in[0] = Z_PI;
      end else begin
         z_in[0] = -Z_PI;
      end
      for (int i = 0; i < NS; i++) begin
         if (!y_ff[i][XW-1]) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + $signed(ZW'(ATAN_TAB[i]));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - $signed(ZW'(ATAN_TAB[i]));
         end
      end
   end

   // gain correction, phase rounding, squares
   always_comb begin
      ux      = x_ff[NS][XW-1] ? '0 : x_ff[NS][XW-2:0];
      hc_in   = HC_W'(ux[XW-2:LOW_W]) * HC_W'(GAIN_FIX);
      lc_full = LC_W'(ux[LOW_W-1:0]) * LC_W'(GAIN_FIX);
      lc_in   = lc_full[LC_W-1:LOW_W];
      zr      = z_ff[NS] + Z_HALF;
      zs      = zr >>> 16;
      if (zs > PH_MAX) begin
         ph_in = PH_MAX[PHASE_W-1:0];
      end else if (zs < PH_MIN) begin
         ph_in = PH_MIN[PHASE_W-1:0];
      end else begin
         ph_in = zs[PHASE_W-1:0];
      end
      sq_re_w = $signed({{SW{real_ff[NS][SW-1]}}, real_ff[NS]}) *
                $signed({{SW{real_ff[NS][SW-1]}}, real_ff[NS]});
      sq_im_w = $signed({{SW{imag_ff[NS][SW-1]}}, imag_ff[NS]}) *
                $signed({{SW{imag_ff[NS][SW-1]}}, imag_ff[NS]});
   end

   // final select
   always_comb begin
      p     = PW'(hc_ff) + PW'(lc_ff) + MAG_HALF;
      mag_w = p >> MAG_SHIFT;
      case (ctl_ff[NS+1].kind)
         KIND_REAL: value_in = {{(VALUE_W - SW){real_ff[NS+1][SW-1]}}, real_ff[NS+1]};
         KIND_IMAG: value_in = {{(VALUE_W - SW){imag_ff[NS+1][SW-1]}}, imag_ff[NS+1]};
         KIND_MAG:  value_in = VALUE_W'(mag_w);
         KIND_PHASE: begin
            value_in = zero_ff[NS+1] ? '0 :
                       {{(VALUE_W - PHASE_W){ph_ff[PHASE_W-1]}}, ph_ff};
         end
         KIND_MAG_SQ: value_in = VALUE_W'(sq_re_ff) + VALUE_W'(sq_im_ff);
         default:   value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[NS:0], in_valid};
         out_valid_ff <= valid_ff[NS+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= NS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         ctl_ff[0]  <= in_ctl;
         real_ff[0] <= in_real;
         imag_ff[0] <= in_imag;
         zero_ff[0] <= (in_real == '0) && (in_imag == '0);
         for (int i = 0; i <= NS; i++) begin
            ctl_ff[i+1]  <= ctl_ff[i];
            real_ff[i+1] <= real_ff[i];
            imag_ff[i+1] <= imag_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
         hc_ff     <= hc_in;
         lc_ff     <= lc_in;
         ph_ff     <= ph_in;
         sq_re_ff  <= sq_re_w;
         sq_im_ff  <= sq_im_w;
         value_ff  <= value_in;
         status_ff <= ctl_ff[NS+1].status;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_value  = value_ff;
   assign out_status = status_ff;

endmodule

`default_nettype wire

// File: design/complex_component_extract.sv
// complex_component_extract: one complex sample in, one component out.
// req channel: a beat carries real and imaginary parts, the x,y position and
// the mode (tuser). rsp channel: a beat carries the value (tdata) and a status
// code (tuser): ok, position out of bounds, or unknown mode (value zero).
// csr port: write frame_width (index 0) or frame_height (index 1) while idle.
// An accepted req beat reaches rsp_tvalid through the input register, the
// queue, the prerotation stage, CORDIC_STAGES rotation stages, the
// gain/multiply stage and the output register. Throughput is one beat per
// cycle while rsp_tready is high.
// Reset sets both frame sizes to MAX_DIM and empties every stage.
// When rsp_tready is low the back pipeline holds; up to four beats collect
// in the queue plus one in the input register, then req_tready goes low.
`default_nettype none

`include "complex_component_extract_macros.svh"

module complex_component_extract
   import cce_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int POS_W         = $clog2(MAX_DIM),
   parameter int CFG_W         = POS_W + 1,
   parameter int VALUE_W       = 2 * SAMPLE_WIDTH + 1,
   parameter int REQ_DATA_W    = ((2 * SAMPLE_WIDTH + 2 * POS_W + 7) / 8) * 8,
   parameter int RSP_DATA_W    = ((VALUE_W + 7) / 8) * 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [REQ_DATA_W-1:0]   req_tdata,   // real_part, imag_part, pos_x, pos_y
   input  wire  [MODE_W-1:0]       req_tuser,   // mode
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // value
   output logic [STATUS_W-1:0]     rsp_tuser,   // status
   input  wire                     csr_wr_en,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CFG_W-1:0]        csr_wr_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CTL_W = $bits(ctl_type);
   localparam int Q_W   = CTL_W + 2 * SW;

   logic                 f_valid, f_ready;
   ctl_type              f_ctl;
   logic signed [SW-1:0] f_real, f_imag;
   logic [Q_W-1:0]       q_push_data, q_pop_data;
   logic                 q_pop_valid, q_pop_ready;
   ctl_type              b_ctl;
   logic signed [SW-1:0] b_real, b_imag;
   logic [VALUE_W-1:0]   rsp_value;
   logic                 rsp_err;

   cce_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_DIM      (MAX_DIM),
      .POS_W        (POS_W),
      .CFG_W        (CFG_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_real    (req_tdata[SW-1:0]),
      .req_imag    (req_tdata[2*SW-1:SW]),
      .req_pos_x   (req_tdata[2*SW+POS_W-1:2*SW]),
      .req_pos_y   (req_tdata[2*SW+2*POS_W-1:2*SW+POS_W]),
      .req_mode    (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .out_ctl     (f_ctl),
      .out_real    (f_real),
      .out_imag    (f_imag)
   );

   assign q_push_data = {f_ctl, f_real, f_imag};

   cce_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   assign b_ctl  = ctl_type'(q_pop_data[Q_W-1:2*SW]);
   assign b_real = q_pop_data[2*SW-1:SW];
   assign b_imag = q_pop_data[SW-1:0];

   cce_back #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES),
      .VALUE_W       (VALUE_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_pop_valid),
      .in_ready   (q_pop_ready),
      .in_ctl     (b_ctl),
      .in_real    (b_real),
      .in_imag    (b_imag),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (rsp_value),
      .out_status (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_value);
   assign rsp_err   = rsp_tvalid && (rsp_tuser != STATUS_OK);

   `CCE_ASSERT_IMP(a_error_beat_zero, clock, reset, rsp_err, rsp_tdata == '0, "error beat nonzero")
   `CCE_ASSERT_NXT(a_reset_empties_output, clock, reset, !rsp_tvalid, "rsp valid after reset")

endmodule

`default_nettype wire

// File: verif/tb_complex_component_extract.sv
`default_nettype none

module tb_complex_component_extract;
   import cce_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W         = 56;
   localparam int RSP_W         = 40;
   localparam int STAGES        = 16;
   localparam int GUARD         = 14;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int NUM_DIRECTED  = 23;

   localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

   localparam longint PI_ANGLE = 64'sd2147483648;
   localparam longint unsigned GAIN_CORR = 64'd652032874;

   // atan(2^-i) in units of pi/2^31
   localparam longint ATAN_STEP [STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861
   };

   typedef struct packed {
      logic [32:0]         value;
      logic [STATUS_W-1:0] status;
   } component_t;

   typedef struct packed {
      logic [10:0]         frame_w;
      logic [10:0]         frame_h;
      logic [15:0]         re;
      logic [15:0]         im;
      logic [9:0]          px;
      logic [9:0]          py;
      logic [MODE_W-1:0]   mode;
      logic                typed;
      logic [32:0]         value;
      logic [STATUS_W-1:0] status;
   } directed_row_t;

   localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{11'd1024, 11'd1024, 16'h7FFF, 16'h8000, 10'd0, 10'd0, MODE_REAL,
        1'b1, 33'h0_0000_7FFF, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h8000, 16'h7FFF, 10'd1023, 10'd1023, MODE_IMAG,
        1'b1, 33'h0_0000_7FFF, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h8000, 16'h0000, 10'd0, 10'd0, MODE_REAL,
        1'b1, 33'h1_FFFF_8000, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h0000, 16'h8000, 10'd5, 10'd9, MODE_IMAG,
        1'b1, 33'h1_FFFF_8000, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h8000, 16'h8000, 10'd3, 10'd7, MODE_MAG_SQ,
        1'b1, 33'h0_8000_0000, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h0000, 16'h0000, 10'd1, 10'd1, MODE_MAG_SQ,
        1'b1, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h0000, 16'h0000, 10'd2, 10'd2, MODE_MAG,
        1'b1, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h0000, 16'h0000, 10'd3, 10'd3, MODE_PHASE,
        1'b1, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'hFC18, 16'h0000, 10'd4, 10'd4, MODE_PHASE,
        1'b1, 33'h0_0000_7FFF, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h8000, 16'h0000, 10'd5, 10'd5, MODE_PHASE,
        1'b1, 33'h0_0000_7FFF, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h03E8, 16'h0000, 10'd6, 10'd6, MODE_PHASE,
        1'b0, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h7FFF, 16'h7FFF, 10'd7, 10'd7, MODE_MAG,
        1'b0, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h8000, 16'h8000, 10'd8, 10'd8, MODE_MAG,
        1'b0, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h8000, 16'hFFFF, 10'd9, 10'd9, MODE_PHASE,
        1'b0, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h0000, 16'h7FFF, 10'd10, 10'd10, MODE_PHASE,
        1'b0, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h0000, 16'h8000, 10'd11, 10'd11, MODE_PHASE,
        1'b0, 33'h0, STATUS_OK},
      '{11'd1024, 11'd1024, 16'h1234, 16'hABCD, 10'd12, 10'd12, MODE_RSVD_LO,
        1'b1, 33'h0, STATUS_BAD_MODE},
      '{11'd1024, 11'd1024, 16'h7FFF, 16'h8000, 10'd1023, 10'd1023, MODE_RSVD_HI,
        1'b1, 33'h0, STATUS_BAD_MODE},
      '{11'd512, 11'd256, 16'h0064, 16'hFF9C, 10'd511, 10'd255, MODE_REAL,
        1'b1, 33'h0_0000_0064, STATUS_OK},
      '{11'd512, 11'd256, 16'h0064, 16'hFF9C, 10'd512, 10'd0, MODE_MAG,
        1'b1, 33'h0, STATUS_BAD_POS},
      '{11'd512, 11'd256, 16'h0064, 16'hFF9C, 10'd0, 10'd256, MODE_PHASE,
        1'b1, 33'h0, STATUS_BAD_POS},
      '{11'd512, 11'd256, 16'h7FFF, 16'h7FFF, 10'd1023, 10'd1023, MODE_RSVD_HI,
        1'b1, 33'h0, STATUS_BAD_POS},
      '{11'd512, 11'd256, 16'h0003, 16'hFFFC, 10'd100, 10'd100, MODE_MAG,
        1'b0, 33'h0, STATUS_OK}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;    // real_part, imag_part, pos_x, pos_y
   logic [MODE_W-1:0]      req_tuser = '0;    // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;         // value
   logic [STATUS_W-1:0]    rsp_tuser;         // status
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [10:0]            csr_wr_data = '0;

   logic [10:0]  frame_w_cfg = 11'd1024;
   logic [10:0]  frame_h_cfg = 11'd1024;
   component_t   pending_components [$];
   int           errors = 0;
   int           cycles = 0;
   int           hold_left = 0;
   bit           hold_request = 1'b0;
   bit           steady = 1'b0;

   complex_component_extract u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic component_t predict_component(input logic [15:0] re_bits,
         input logic [15:0] im_bits, input logic [9:0] px, input logic [9:0] py,
         input logic [MODE_W-1:0] mode);
      longint re, im, x, y, z, dx, dy, val;
      longint unsigned ux, h, l, p;
      component_t res;
      re = longint'($signed(re_bits));
      im = longint'($signed(im_bits));
      val = 0;
      res.status = STATUS_OK;
      if ({1'b0, px} >= frame_w_cfg || {1'b0, py} >= frame_h_cfg) begin
         res.status = STATUS_BAD_POS;
      end else begin
         case (mode)
            MODE_REAL: begin
               val = re;
            end
            MODE_IMAG: begin
               val = im;
            end
            MODE_MAG_SQ: begin
               val = re * re + im * im;
            end
            MODE_MAG, MODE_PHASE: begin
               if (re != 0 || im != 0) begin
                  x = re <<< GUARD;
                  y = im <<< GUARD;
                  z = 0;
                  if (re < 0) begin
                     x = -x;
                     y = -y;
                     z = (im >= 0) ? PI_ANGLE : -PI_ANGLE;
                  end
                  for (int i = 0; i < STAGES; i++) begin
                     dx = y >>> i;
                     dy = x >>> i;
                     if (y >= 0) begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ATAN_STEP[i];
                     end else begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ATAN_STEP[i];
                     end
                  end
                  if (mode == MODE_PHASE) begin
                     z = (z + 32768) >>> 16;
                     if (z > 32767) z = 32767;
                     if (z < -32768) z = -32768;
                     val = z;
                  end else begin
                     ux = (x < 0) ? 64'd0 : longint'(x);
                     h = ux >> 16;
                     l = ux & 64'hFFFF;
                     p = h * GAIN_CORR + ((l * GAIN_CORR) >> 16);
                     val = longint'((p + (64'd1 << (GUARD + 13))) >> (GUARD + 14));
                  end
               end
            end
            default: begin
               res.status = STATUS_BAD_MODE;
            end
         endcase
      end
      res.value = val[32:0];
      return res;
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'(int'($urandom_range(16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [9:0] pick_pos(input logic [10:0] frame);
      int lim;
      lim = (frame > 11'd1024) ? 1024 : int'(frame);
      if (lim > 0 && $urandom_range(99) < 85) return 10'($urandom_range(lim - 1));
      return 10'($urandom);
   endfunction

   task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
         input logic [9:0] px, input logic [9:0] py, input logic [MODE_W-1:0] mode,
         input logic typed, input component_t typed_result);
      component_t want;
      int gap;
      want = typed ? typed_result : predict_component(re, im, px, py, mode);
      gap = 0;
      while (!steady && $urandom_range(99) < 17) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, py, px, im, re};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_components.push_back(want);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_components.size() != 0) @(posedge clock);
   endtask

   task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_FRAME_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index   <= CSR_FRAME_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      frame_w_cfg = w;
      frame_h_cfg = h;
   endtask

   task automatic run_random(input logic [10:0] w, input logic [10:0] h,
         input int count, input bit calm, input bit hold);
      logic [15:0] re, im;
      logic [9:0] px, py;
      logic [MODE_W-1:0] mode;
      wait_idle();
      set_frame(w, h);
      steady = calm;
      if (hold) hold_request = 1'b1;
      for (int k = 0; k < count; k++) begin
         re = pick_sample();
         im = pick_sample();
         px = pick_pos(w);
         py = pick_pos(h);
         mode = ($urandom_range(99) < 85) ? MODE_W'($urandom_range(4))
                                          : MODE_W'($urandom_range(7));
         send_sample(re, im, px, py, mode, 1'b0, '0);
      end
   endtask

   // sink side: random backpressure, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      component_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_components.size() == 0) begin
            $error("rsp beat with nothing pending: value %0d status %0d",
                   $signed(rsp_tdata[32:0]), rsp_tuser);
            errors++;
         end else begin
            want = pending_components.pop_front();
            if (rsp_tdata[32:0] !== want.value) begin
               $error("value: expected %0d, got %0d", $signed(want.value),
                      $signed(rsp_tdata[32:0]));
               errors++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < NUM_DIRECTED; n++) begin
         if (DIRECTED_ROWS[n].frame_w != frame_w_cfg ||
             DIRECTED_ROWS[n].frame_h != frame_h_cfg) begin
            wait_idle();
            set_frame(DIRECTED_ROWS[n].frame_w, DIRECTED_ROWS[n].frame_h);
         end
         send_sample(DIRECTED_ROWS[n].re, DIRECTED_ROWS[n].im, DIRECTED_ROWS[n].px,
                     DIRECTED_ROWS[n].py, DIRECTED_ROWS[n].mode, DIRECTED_ROWS[n].typed,
                     '{DIRECTED_ROWS[n].value, DIRECTED_ROWS[n].status});
      end

      run_random(11'd2047, 11'd2047, 200, 1'b0, 1'b1);
      run_random(11'd1, 11'd1, 80, 1'b0, 1'b0);
      run_random(11'd0, 11'd1024, 50, 1'b0, 1'b0);
      run_random(11'd1024, 11'd0, 50, 1'b0, 1'b0);
      run_random(11'd1024, 11'd1024, 200, 1'b1, 1'b0);
      repeat (3) begin
         run_random(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                    90, 1'b0, 1'b0);
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/cce_pkg.sv
design/cce_front.sv
design/cce_queue.sv
design/cce_back.sv
design/complex_component_extract.sv
verif/tb_complex_component_extract.sv
